// File: rtl/yfho_pkg.sv
// Shared types, constants and the operation schedule of the yaw-frame high-pass offset unit.
package yfho_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_CANCEL_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_CONSTANT = 2'd1;

  localparam logic [23:0] TAU_MIN_US     = 24'd20000;
  localparam logic [23:0] TAU_DEFAULT_US = 24'd400000;
  localparam logic [23:0] DT_MAX_US      = 24'd500000;

  localparam logic signed [33:0] POLY_C0 = 34'sd1686629713;
  localparam logic signed [33:0] POLY_C1 = -34'sd693598664;
  localparam logic signed [33:0] POLY_C2 = 34'sd85569307;
  localparam logic signed [33:0] POLY_C3 = -34'sd5026994;
  localparam logic signed [33:0] POLY_C4 = 34'sd172273;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int NUM_STEPS = 23;
  localparam int STEP_W    = 5;

  typedef enum logic [4:0] {
    OP_X2, OP_H3, OP_H2, OP_H1, OP_H0, OP_HXS, OP_HXC,
    OP_R1, OP_R2, OP_R3, OP_R4,
    OP_L1, OP_L2, OP_L3,
    OP_B1, OP_B2, OP_B3, OP_B4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic wb_en;
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic item_zero;
    logic div_busy;
  } status_t;

  function automatic op_t step_op(input logic [STEP_W-1:0] step);
    op_t op;
    unique case (step)
      5'd0, 5'd6: op = OP_X2;
      5'd1, 5'd7: op = OP_H3;
      5'd2, 5'd8: op = OP_H2;
      5'd3, 5'd9: op = OP_H1;
      5'd4, 5'd10: op = OP_H0;
      5'd5: op = OP_HXS;
      5'd11: op = OP_HXC;
      5'd12: op = OP_R1;
      5'd13: op = OP_R2;
      5'd14: op = OP_R3;
      5'd15: op = OP_R4;
      5'd16: op = OP_L1;
      5'd17: op = OP_L2;
      5'd18: op = OP_L3;
      5'd19: op = OP_B1;
      5'd20: op = OP_B2;
      5'd21: op = OP_B3;
      default: op = OP_B4;
    endcase
    return op;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/yfho_div.sv
// Restoring divider producing the Q24 filter coefficient, one quotient bit per cycle.
module yfho_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dt,
  input  logic [23:0] tau,
  output logic [24:0] alpha,
  output logic        busy
);

  logic [23:0] rem_r, rem_nxt;
  logic [23:0] div_r, div_nxt;
  logic [24:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [24:0] rem2;
  logic        ge;

  always_comb begin
    rem2     = {rem_r, 1'b0};
    ge       = rem2 >= {1'b0, div_r};
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      div_nxt = tau;
      if (dt >= tau) begin
        q_nxt    = 25'h100_0000;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = dt;
        q_nxt    = '0;
        cnt_nxt  = 5'd24;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? 24'(rem2 - {1'b0, div_r}) : rem2[23:0];
      q_nxt    = {q_r[23:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      busy_nxt = cnt_r != 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign alpha = q_r;
  assign busy  = busy_r;

endmodule

// File: rtl/yfho_ctrl.sv
// Sequencer that steps the datapath through the sine, rotation and filter operations.
module yfho_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  yfho_pkg::status_t  status,
  output yfho_pkg::cmd_t     cmd
);

  yfho_pkg::state_t             state_r, state_nxt;
  logic [yfho_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         in_acc;

  assign in_stall = state_r != yfho_pkg::ST_IDLE;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.op        = yfho_pkg::step_op(step_r);
    unique case (state_r)
      yfho_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          step_nxt    = '0;
          state_nxt   = status.item_zero ? yfho_pkg::ST_DONE : yfho_pkg::ST_MUL;
        end
      end
      yfho_pkg::ST_MUL: begin
        if (!(cmd.op == yfho_pkg::OP_L1 && status.div_busy)) begin
          cmd.mul_en = 1'b1;
          state_nxt  = yfho_pkg::ST_WB;
        end
      end
      yfho_pkg::ST_WB: begin
        cmd.wb_en = 1'b1;
        if (step_r == yfho_pkg::STEP_W'(yfho_pkg::NUM_STEPS - 1)) begin
          state_nxt = yfho_pkg::ST_DONE;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = yfho_pkg::ST_MUL;
        end
      end
      yfho_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = yfho_pkg::ST_IDLE;
        end
      end
      default: state_nxt = yfho_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= yfho_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !status.item_zero) |=> (state_r == yfho_pkg::ST_MUL && step_r == '0))
    else $error("computation did not start at the first step");
  a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == yfho_pkg::ST_WB) |-> ($past(state_r) == yfho_pkg::ST_MUL))
    else $error("write-back without a preceding multiply");
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == yfho_pkg::ST_DONE))
    else $error("result presented without a finished item");
`endif

endmodule

// File: rtl/yfho_dp.sv
// Datapath with the shared multiplier, sine-cosine registers, filter state and result registers.
module yfho_dp #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  yfho_pkg::cmd_t                      cmd,
  output yfho_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  logic [yfho_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [yfho_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_measurement_valid,
  input  logic [23:0]                         in_elapsed_us,
  input  logic signed [31:0]                  in_camera_x,
  input  logic signed [31:0]                  in_camera_y,
  input  logic signed [31:0]                  in_camera_z,
  input  logic signed [31:0]                  in_root_x,
  input  logic signed [31:0]                  in_root_y,
  input  logic signed [31:0]                  in_root_z,
  input  logic [15:0]                         in_yaw_angle,
  output logic signed [31:0]                  out_offset_x,
  output logic signed [31:0]                  out_offset_y,
  output logic signed [31:0]                  out_offset_z
);

  localparam int UP   = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int DOWN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  logic               cancel_r;
  logic [23:0]        tau_r;
  logic               primed_r;
  logic signed [31:0] smx_r, smy_r, smz_r;

  logic signed [32:0] wx_r, wy_r;
  logic [1:0]         quad_r;
  logic [30:0]        xb_r, qx_r, x2_r;
  logic signed [33:0] acc_r;
  logic signed [31:0] s0_r, s_r, c_r;
  logic signed [37:0] t_r;
  logic signed [31:0] lx_r, ly_r, lz_r;
  logic               reload_r;
  logic signed [67:0] prod_r;
  logic signed [31:0] rx_r, ry_r, rz_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  logic [15+UP:0]          yaw_ext;
  logic [ANGLE_BITS-1:0]   ang;
  logic [23:0]             tau_eff;
  logic signed [32:0]      wz;
  logic signed [33:0]      mul_a, mul_b;
  logic signed [37:0]      p30;
  logic signed [67:0]      prnd;
  logic signed [32:0]      dx, dy, dz;
  logic signed [31:0]      clampv;
  logic signed [31:0]      sm_upd;
  logic signed [31:0]      sm_sel;
  logic [24:0]             alpha;
  logic                    div_busy;

  assign yaw_ext = (16 + UP)'(in_yaw_angle) << UP;
  assign ang     = ANGLE_BITS'(yaw_ext >> DOWN);
  assign tau_eff = (tau_r > yfho_pkg::TAU_MIN_US) ? tau_r : yfho_pkg::TAU_DEFAULT_US;
  assign wz      = 33'(in_camera_z) - 33'(in_root_z);

  assign status.item_zero = !cancel_r || !in_measurement_valid;
  assign status.div_busy  = div_busy;

  yfho_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.capture),
    .dt    (in_elapsed_us),
    .tau   (tau_eff),
    .alpha (alpha),
    .busy  (div_busy)
  );

  assign dx = 33'(lx_r) - 33'(smx_r);
  assign dy = 33'(ly_r) - 33'(smy_r);
  assign dz = 33'(lz_r) - 33'(smz_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      yfho_pkg::OP_X2: begin
        mul_a = 34'(qx_r);
        mul_b = 34'(qx_r);
      end
      yfho_pkg::OP_H3, yfho_pkg::OP_H2, yfho_pkg::OP_H1, yfho_pkg::OP_H0: begin
        mul_a = acc_r;
        mul_b = 34'(x2_r);
      end
      yfho_pkg::OP_HXS, yfho_pkg::OP_HXC: begin
        mul_a = acc_r;
        mul_b = 34'(qx_r);
      end
      yfho_pkg::OP_R1: begin mul_a = 34'(wx_r); mul_b = 34'(c_r); end
      yfho_pkg::OP_R2: begin mul_a = 34'(wy_r); mul_b = 34'(s_r); end
      yfho_pkg::OP_R3: begin mul_a = 34'(wy_r); mul_b = 34'(c_r); end
      yfho_pkg::OP_R4: begin mul_a = 34'(wx_r); mul_b = 34'(s_r); end
      yfho_pkg::OP_L1: begin mul_a = 34'(dx); mul_b = 34'(alpha); end
      yfho_pkg::OP_L2: begin mul_a = 34'(dy); mul_b = 34'(alpha); end
      yfho_pkg::OP_L3: begin mul_a = 34'(dz); mul_b = 34'(alpha); end
      yfho_pkg::OP_B1: begin mul_a = 34'(dx); mul_b = 34'(c_r); end
      yfho_pkg::OP_B2: begin mul_a = 34'(dy); mul_b = 34'(s_r); end
      yfho_pkg::OP_B3: begin mul_a = 34'(dx); mul_b = 34'(s_r); end
      yfho_pkg::OP_B4: begin mul_a = 34'(dy); mul_b = 34'(c_r); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p30  = prod_r[67:30];
  assign prnd = prod_r + 68'sd8388608;

  always_comb begin
    if (p30 < 38'sd0) begin
      clampv = '0;
    end else if (p30 > 38'(yfho_pkg::Q30_ONE)) begin
      clampv = 32'(yfho_pkg::Q30_ONE);
    end else begin
      clampv = p30[31:0];
    end
  end

  always_comb begin
    case (cmd.op)
      yfho_pkg::OP_L1: sm_sel = smx_r;
      yfho_pkg::OP_L2: sm_sel = smy_r;
      default:         sm_sel = smz_r;
    endcase
    sm_upd = sm_sel + prnd[55:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cancel_r <= 1'b0;
      tau_r    <= yfho_pkg::TAU_DEFAULT_US;
      primed_r <= 1'b0;
      smx_r    <= '0;
      smy_r    <= '0;
      smz_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          yfho_pkg::REG_CANCEL_ENABLE: cancel_r <= cfg_data[0];
          yfho_pkg::REG_TIME_CONSTANT: tau_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture && !status.item_zero) begin
        primed_r <= 1'b1;
      end
      if (cmd.wb_en) begin
        case (cmd.op)
          yfho_pkg::OP_L1: smx_r <= reload_r ? lx_r : sm_upd;
          yfho_pkg::OP_L2: smy_r <= reload_r ? ly_r : sm_upd;
          yfho_pkg::OP_L3: smz_r <= reload_r ? lz_r : sm_upd;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wx_r     <= 33'(in_camera_x) - 33'(in_root_x);
      wy_r     <= 33'(in_camera_y) - 33'(in_root_y);
      lz_r     <= yfho_pkg::sat32(40'(wz));
      quad_r   <= ang[ANGLE_BITS-1 -: 2];
      xb_r     <= 31'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      qx_r     <= 31'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      reload_r <= !primed_r || in_elapsed_us == '0 || in_elapsed_us > yfho_pkg::DT_MAX_US;
      rx_r     <= '0;
      ry_r     <= '0;
      rz_r     <= '0;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.wb_en) begin
      case (cmd.op)
        yfho_pkg::OP_X2: begin
          x2_r  <= p30[30:0];
          acc_r <= yfho_pkg::POLY_C4;
        end
        yfho_pkg::OP_H3: acc_r <= 34'(38'(yfho_pkg::POLY_C3) + p30);
        yfho_pkg::OP_H2: acc_r <= 34'(38'(yfho_pkg::POLY_C2) + p30);
        yfho_pkg::OP_H1: acc_r <= 34'(38'(yfho_pkg::POLY_C1) + p30);
        yfho_pkg::OP_H0: acc_r <= 34'(38'(yfho_pkg::POLY_C0) + p30);
        yfho_pkg::OP_HXS: begin
          s0_r <= clampv;
          qx_r <= yfho_pkg::Q30_ONE - xb_r;
        end
        yfho_pkg::OP_HXC: begin
          case (quad_r)
            2'd0: begin s_r <= s0_r;    c_r <= clampv;  end
            2'd1: begin s_r <= clampv;  c_r <= -s0_r;   end
            2'd2: begin s_r <= -s0_r;   c_r <= -clampv; end
            default: begin s_r <= -clampv; c_r <= s0_r; end
          endcase
        end
        yfho_pkg::OP_R1, yfho_pkg::OP_R3, yfho_pkg::OP_B1, yfho_pkg::OP_B3: t_r <= p30;
        yfho_pkg::OP_R2: lx_r <= yfho_pkg::sat32(40'(t_r) + 40'(p30));
        yfho_pkg::OP_R4: ly_r <= yfho_pkg::sat32(40'(t_r) - 40'(p30));
        yfho_pkg::OP_B2: rx_r <= yfho_pkg::sat32(40'(t_r) - 40'(p30));
        yfho_pkg::OP_B4: begin
          ry_r <= yfho_pkg::sat32(40'(t_r) + 40'(p30));
          rz_r <= yfho_pkg::sat32(40'(dz));
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      ox_r <= rx_r;
      oy_r <= ry_r;
      oz_r <= rz_r;
    end
  end

  assign out_offset_x = ox_r;
  assign out_offset_y = oy_r;
  assign out_offset_z = oz_r;

endmodule

// File: rtl/yaw_frame_highpass_offset_unit.sv
// Top level of the yaw-frame high-pass offset unit.
//
// The input channel takes one item with camera and root positions, a yaw angle and the
// elapsed time; the result channel returns one item with the high-pass world offset.
// An item is taken when in_valid is high and in_stall is low, a result when out_valid
// is high and out_stall is low. The configuration port writes cancel_enable (index 0)
// and time_constant_us (index 1); it is always ready. The user must see that it is written
// only while idle; the block itself does not enforce this. A measured item runs 23 multiply
// and write-back steps on one shared multiplier, and no new item is taken until its result
// is loaded. The coefficient divider runs beside the sine steps and does not add time.
// An item that is invalid or arrives with cancel off skips the steps and gives a zero
// result, and the next item can be taken once that result is loaded.
// The result sits in an output register; the next item is accepted while it waits, and
// a stalled receiver holds the block only once the following result is finished.
// Reset clears the filter state, sets cancel off and the time constant to 400000 us.
module yaw_frame_highpass_offset_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_measurement_valid,
  input  logic [23:0]                      in_elapsed_us,
  input  logic signed [31:0]               in_camera_x,
  input  logic signed [31:0]               in_camera_y,
  input  logic signed [31:0]               in_camera_z,
  input  logic signed [31:0]               in_root_x,
  input  logic signed [31:0]               in_root_y,
  input  logic signed [31:0]               in_root_z,
  input  logic [15:0]                      in_yaw_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_offset_x,
  output logic signed [31:0]               out_offset_y,
  output logic signed [31:0]               out_offset_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yfho_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yfho_pkg::CFG_DATA_W-1:0]  cfg_data
);

  yfho_pkg::cmd_t    cmd;
  yfho_pkg::status_t status;

  assign cfg_ready = 1'b1;

  yfho_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  yfho_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_measurement_valid (in_measurement_valid),
    .in_elapsed_us        (in_elapsed_us),
    .in_camera_x          (in_camera_x),
    .in_camera_y          (in_camera_y),
    .in_camera_z          (in_camera_z),
    .in_root_x            (in_root_x),
    .in_root_y            (in_root_y),
    .in_root_z            (in_root_z),
    .in_yaw_angle         (in_yaw_angle),
    .out_offset_x         (out_offset_x),
    .out_offset_y         (out_offset_y),
    .out_offset_z         (out_offset_z)
  );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the yaw-frame high-pass offset unit.
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_measurement_valid;
  logic [23:0] in_elapsed_us;
  logic signed [31:0] in_camera_x, in_camera_y, in_camera_z;
  logic signed [31:0] in_root_x, in_root_y, in_root_z;
  logic [15:0] in_yaw_angle;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_offset_x, out_offset_y, out_offset_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [yfho_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [yfho_pkg::CFG_DATA_W-1:0] cfg_data;

  yaw_frame_highpass_offset_unit DUT (.*);

  typedef struct {
    logic meas;
    logic [23:0] dt;
    logic signed [31:0] cx, cy, cz, rx, ry, rz;
    logic [15:0] yaw;
  } sample_t;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
  } offset_t;

  offset_t expected_offsets[$];
  int error_count = 0;
  bit hold_receiver = 0;

  logic flt_enable;
  logic [23:0] flt_tau;
  longint lp_x, lp_y, lp_z;
  bit lp_primed;

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quarter_sine(longint x);
    longint coef[5];
    longint x2, acc;
    coef[0] = 1686629713; coef[1] = -693598664; coef[2] = 85569307;
    coef[3] = -5026994; coef[4] = 172273;
    x2 = fshr(x * x, 30);
    acc = coef[4];
    for (int k = 3; k >= 0; k--) acc = coef[k] + fshr(acc * x2, 30);
    acc = fshr(acc * x, 30);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return acc;
  endfunction

  function automatic longint smooth_step(longint lp, longint tgt, longint alpha);
    return lp + fshr((tgt - lp) * alpha + (64'sd1 << 23), 24);
  endfunction

  function automatic offset_t predict_offset(sample_t it);
    offset_t r;
    longint wx, wy, wz, s, c, s0, c0, x, lx, ly, lz, bx, by, bz, alpha, tau;
    logic [1:0] q;
    r.ox = 0; r.oy = 0; r.oz = 0;
    if (!flt_enable || !it.meas) return r;
    wx = longint'(it.cx) - longint'(it.rx);
    wy = longint'(it.cy) - longint'(it.ry);
    wz = longint'(it.cz) - longint'(it.rz);
    q = it.yaw[15:14];
    x = longint'(it.yaw[13:0]) << 16;
    s0 = quarter_sine(x);
    c0 = quarter_sine((64'sd1 << 30) - x);
    case (q)
      2'd0: begin s = s0; c = c0; end
      2'd1: begin s = c0; c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
    lx = clip32(fshr(wx * c, 30) + fshr(wy * s, 30));
    ly = clip32(fshr(wy * c, 30) - fshr(wx * s, 30));
    lz = clip32(wz);
    tau = (flt_tau > yfho_pkg::TAU_MIN_US) ? flt_tau : yfho_pkg::TAU_DEFAULT_US;
    if (!lp_primed || it.dt == 0 || it.dt > yfho_pkg::DT_MAX_US) begin
      lp_x = lx; lp_y = ly; lp_z = lz; lp_primed = 1'b1;
    end else begin
      alpha = (longint'(it.dt) << 24) / tau;
      if (alpha > (64'sd1 << 24)) alpha = 64'sd1 << 24;
      lp_x = smooth_step(lp_x, lx, alpha);
      lp_y = smooth_step(lp_y, ly, alpha);
      lp_z = smooth_step(lp_z, lz, alpha);
    end
    bx = lx - lp_x; by = ly - lp_y; bz = lz - lp_z;
    r.ox = 32'(clip32(fshr(bx * c, 30) - fshr(by * s, 30)));
    r.oy = 32'(clip32(fshr(bx * s, 30) + fshr(by * c, 30)));
    r.oz = 32'(clip32(bz));
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    offset_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_offsets.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = expected_offsets.pop_front();
        if (out_offset_x !== e.ox) report_mismatch("offset_x", out_offset_x, e.ox);
        if (out_offset_y !== e.oy) report_mismatch("offset_y", out_offset_y, e.oy);
        if (out_offset_z !== e.oz) report_mismatch("offset_z", out_offset_z, e.oz);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_receiver) begin
      out_stall <= hold_receiver;
    end else begin
      case ($urandom_range(0, 3))
        0: out_stall <= ($urandom_range(0, 1) == 0);
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_sample(sample_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_measurement_valid <= it.meas;
    in_elapsed_us <= it.dt;
    in_camera_x <= it.cx; in_camera_y <= it.cy; in_camera_z <= it.cz;
    in_root_x <= it.rx; in_root_y <= it.ry; in_root_z <= it.rz;
    in_yaw_angle <= it.yaw;
    do @(posedge clk); while (in_stall);
    expected_offsets.push_back(predict_offset(it));
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [yfho_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] val);
    wait (expected_offsets.size() == 0);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == yfho_pkg::REG_CANCEL_ENABLE) flt_enable = val[0];
    else if (idx == yfho_pkg::REG_TIME_CONSTANT) flt_tau = val;
  endtask

  function automatic sample_t random_sample(bit near);
    sample_t it;
    it.meas = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0: it.dt = '0;
      1: it.dt = 24'($urandom);
      2: it.dt = 24'($urandom_range(499990, 500010));
      default: it.dt = 24'($urandom_range(1, 40000));
    endcase
    it.yaw = 16'($urandom);
    if (near) begin
      it.rx = $urandom; it.ry = $urandom; it.rz = $urandom;
      it.cx = it.rx + $signed($urandom_range(0, 2000000) - 1000000);
      it.cy = it.ry + $signed($urandom_range(0, 2000000) - 1000000);
      it.cz = it.rz + $signed($urandom_range(0, 20000000));
    end else begin
      it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
      it.rx = $urandom; it.ry = $urandom; it.rz = $urandom;
    end
    return it;
  endfunction

  task automatic test_disabled();
    sample_t it;
    for (int i = 0; i < 4; i++) begin
      it = random_sample(0);
      it.meas = 1;
      send_sample(it);
    end
  endtask

  task automatic test_directed();
    sample_t it;
    write_reg(yfho_pkg::REG_CANCEL_ENABLE, 24'd1);
    write_reg(yfho_pkg::REG_TIME_CONSTANT, 24'd20000);
    it.meas = 1; it.dt = 24'd16000;
    it.cx = 32'sh7FFF_FFFF; it.cy = 32'sh8000_0000; it.cz = 32'sh7FFF_FFFF;
    it.rx = 32'sh8000_0000; it.ry = 32'sh7FFF_FFFF; it.rz = 32'sh8000_0000;
    for (int i = 0; i < 8; i++) begin
      it.yaw = 16'(16'h2000 * i + ((i == 7) ? 16'h1FFF : 16'h0));
      send_sample(it);
    end
    it.dt = '0; send_sample(it);
    it.dt = 24'd500000; send_sample(it);
    it.dt = 24'd500001; send_sample(it);
    it.dt = 24'hFFFFFF; send_sample(it);
    it.meas = 0; it.dt = 24'd1000; send_sample(it);
    it.meas = 1;
    it.cx = 0; it.cy = 32'sd6553600; it.cz = 32'sd1000;
    it.rx = 32'sd100; it.ry = 0; it.rz = 0; it.yaw = 16'hFFFF;
    send_sample(it);
    it.dt = 24'd1; send_sample(it);
    it.cy = -32'sd6553600; it.dt = 24'd19999; send_sample(it);
    write_reg(yfho_pkg::REG_TIME_CONSTANT, 24'd20001);
    it.dt = 24'd40000; send_sample(it);
    write_reg(yfho_pkg::REG_TIME_CONSTANT, 24'hFFFFFF);
    it.dt = 24'd499999; send_sample(it);
    write_reg(yfho_pkg::REG_TIME_CONSTANT, 24'd0);
    it.cz = -32'sd5000; send_sample(it);
    write_reg(2'd3, 24'hFFFFFF);
    send_sample(it);
  endtask

  task automatic test_random();
    logic [23:0] taus[4];
    taus[0] = 24'd400000; taus[1] = 24'd30000; taus[2] = 24'hFFFFFF; taus[3] = 24'd5000;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(yfho_pkg::REG_CANCEL_ENABLE, (phase == 3) ? 24'd0 : 24'd1);
      write_reg(yfho_pkg::REG_TIME_CONSTANT, (phase < 4) ? taus[phase] : 24'($urandom));
      for (int i = 0; i < 320; i++) send_sample(random_sample($urandom_range(0, 4) != 0));
    end
  endtask

  task automatic test_backpressure();
    write_reg(yfho_pkg::REG_CANCEL_ENABLE, 24'd1);
    hold_receiver = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 10; i++) begin
        burst_left = 10;
        send_sample(random_sample(1));
      end
    join
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_measurement_valid = 0; in_elapsed_us = 0;
    in_camera_x = 0; in_camera_y = 0; in_camera_z = 0;
    in_root_x = 0; in_root_y = 0; in_root_z = 0; in_yaw_angle = 0;
    out_stall = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    flt_enable = 0; flt_tau = yfho_pkg::TAU_DEFAULT_US;
    lp_x = 0; lp_y = 0; lp_z = 0; lp_primed = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_backpressure();
    test_random();
    wait (expected_offsets.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_offsets.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: yaw_frame_highpass_offset_unit.f
rtl/yfho_pkg.sv
rtl/yfho_div.sv
rtl/yfho_ctrl.sv
rtl/yfho_dp.sv
rtl/yaw_frame_highpass_offset_unit.sv
dv/tb_top.sv
